// File: design/laser_pulse_source_generator_defines.svh
// assertion macros for the laser pulse source generator
// used by the top level; bodies drop out when SYNTHESIS is defined
`ifndef LASER_PULSE_SOURCE_GENERATOR_DEFINES_SVH
`define LASER_PULSE_SOURCE_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LPSG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpsg assertion failed");
// next-cycle implication
`define LPSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpsg assertion failed");
`else
`define LPSG_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LPSG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/lpsg_pkg.sv
// shared types, constants and tables of the laser pulse source generator
// no dependencies; imported by every module of the block
package lpsg_pkg;

    localparam int ENVELOPE_TABLE_DEPTH = 256;
    localparam int CORDIC_STAGES        = 16;
    localparam int SAMPLE_WIDTH         = 24;

    localparam int IDX_BITS   = $clog2(ENVELOPE_TABLE_DEPTH);
    localparam int NUM_CELLS  = (CORDIC_STAGES > IDX_BITS) ? CORDIC_STAGES : IDX_BITS;
    localparam int CELL_IDX_W = $clog2(NUM_CELLS);
    localparam int ATAN_COUNT = 24;
    localparam int ATAN_IDX_W = $clog2(ATAN_COUNT);

    localparam int CW      = 34;   // cordic datapath
    localparam int MAG_W   = 34;   // distance into a slope and its 3*width
    localparam int TRIG_W  = 32;   // clamped sine and cosine
    localparam int ENV_W   = 31;   // envelope, q1.30
    localparam int AMP_W   = 23;
    localparam int A_W     = 24;
    localparam int PROD_W  = 57;
    localparam int OUT_W   = 24;

    localparam longint unsigned Q30_ONE       = 64'd1073741824;
    localparam longint unsigned CORDIC_GAIN   = 64'd652032874;
    localparam longint unsigned EXP_MINUS_ONE = 64'd395007543;
    localparam longint          SMAX          = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
    localparam longint          SMIN          = -SMAX - 64'sd1;

    // register map
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RISE_WIDTH   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FALL_WIDTH   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FLAT_LENGTH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FREQ_RATIO   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_OFFSET = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_POLARITY     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ACCUMULATE   = 3'd7;

    // polarity codes and write masks
    localparam logic [2:0] POL_E1    = 3'd1;
    localparam logic [2:0] POL_P     = 3'd2;
    localparam logic [2:0] POL_S     = 3'd3;
    localparam logic [2:0] POL_RIGHT = 3'd4;
    localparam logic [2:0] POL_LEFT  = 3'd5;
    localparam logic [2:0] MASK_NONE = 3'b000;
    localparam logic [2:0] MASK_E1   = 3'b001;
    localparam logic [2:0] MASK_P    = 3'b010;
    localparam logic [2:0] MASK_S    = 3'b100;
    localparam logic [2:0] MASK_PS   = 3'b110;

    typedef enum logic [1:0] {
        RGN_RISE  = 2'd0,
        RGN_FLAT  = 2'd1,
        RGN_FALL  = 2'd2,
        RGN_AFTER = 2'd3
    } region_t;

    typedef logic [31:0] atan_table_t [ATAN_COUNT];
    localparam atan_table_t ATAN_TABLE = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h0511D1D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef logic [ENV_W-1:0] env_table_t [ENVELOPE_TABLE_DEPTH];

    // floor of num over a small den by shift and subtract
    function automatic longint unsigned div_small(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            q   = q << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q   = q | 64'd1;
            end
        end
        return q;
    endfunction

    // exp(-(3*idx/depth)^2) in q1.30, series times e^-1 per whole unit
    function automatic env_table_t build_env_table();
        env_table_t      tbl;
        longint unsigned u;
        longint unsigned v;
        longint unsigned n;
        longint unsigned f;
        longint unsigned term;
        longint unsigned r;
        longint          sum;
        for (int i = 0; i < ENVELOPE_TABLE_DEPTH; i++) begin
            u    = (longint'(i) * 3 * (64'd1 << 28)) / ENVELOPE_TABLE_DEPTH;
            v    = (u * u) >> 26;
            n    = v >> 30;
            f    = v & (Q30_ONE - 64'd1);
            term = Q30_ONE;
            sum  = longint'(Q30_ONE);
            for (int k = 1; k <= 14; k++) begin
                term = div_small((term * f) >> 30, 64'(k));
                if (k[0])
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            r = longint'(sum);
            for (longint unsigned k = 0; k < n && k < 16; k++)
                r = (r * EXP_MINUS_ONE) >> 30;
            tbl[i] = ENV_W'(r);
        end
        return tbl;
    endfunction

    localparam env_table_t ENV_TABLE = build_env_table();

    // data handed from cell to cell
    typedef struct packed {
        logic                     vld;
        region_t                  region;
        logic                     neg;
        logic signed [CW-1:0]     x;
        logic signed [CW-1:0]     y;
        logic signed [CW-1:0]     z;
        logic [MAG_W-1:0]         rem;
        logic [MAG_W-1:0]         divisor;
        logic [IDX_BITS-1:0]      quo;
        logic                     ovf;
        logic                     wzero;
    } cell_bus_t;

    // pulse timing seen by the front end
    typedef struct packed {
        logic [33:0] t1;
        logic [34:0] t2;
        logic [35:0] t3;
        logic [33:0] fall3;
        logic        rise_zero;
        logic        fall_zero;
        logic [23:0] freq_ratio;
        logic [15:0] phase_offset;
    } timing_t;

    // settings seen by the back end
    typedef struct packed {
        logic [AMP_W-1:0] amplitude;
        logic [2:0]       polarity;
        logic             accumulate;
    } out_cfg_t;

endpackage

// File: design/laser_pulse_source_generator.sv
// top level of the laser pulse source generator: register file, front end,
// chain of cordic/divide cells and back end; depends on lpsg_pkg and the defines header
//
//  channel  | signals                              | transfer when
//  ---------+--------------------------------------+---------------------------
//  config   | psel penable pwrite paddr pwdata ... | psel & penable & pwrite
//  input    | in_valid in_ready time_now           | in_valid & in_ready
//  output   | out_valid out_ready e1/p/s_value ... | out_valid & out_ready
//
// one time value per cycle while no result waits unread; the path is 3 front
// stages, a chain of NUM_CELLS registered cells (16 by default) and 4 back stages
// the whole pipeline advances together and holds while a result waits unread
// reset clears registers to defaults and all valid flags; no clearing pass
`include "laser_pulse_source_generator_defines.svh"
module laser_pulse_source_generator
    import lpsg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        time_now,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [OUT_W-1:0]   e1_value,
    output logic [OUT_W-1:0]   p_value,
    output logic [OUT_W-1:0]   s_value,
    output logic [2:0]         write_mask,
    output logic               add_mode,
    output logic [1:0]         pulse_region
);

    logic [AMP_W-1:0] amplitude_reg;
    logic [31:0]      rise_width_reg;
    logic [31:0]      fall_width_reg;
    logic [31:0]      flat_length_reg;
    logic [23:0]      freq_ratio_reg;
    logic [15:0]      phase_offset_reg;
    logic [2:0]       polarity_reg;
    logic             accumulate_reg;

    logic [33:0]      t1_reg;
    logic [34:0]      t2_reg;
    logic [35:0]      t3_reg;
    logic [33:0]      fall3_reg;
    logic [33:0]      t1_next;
    logic [34:0]      t2_next;
    logic [35:0]      t3_next;
    logic [33:0]      fall3_next;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 adv;
    timing_t              tm;
    out_cfg_t             oc;
    cell_bus_t            cell_bus [NUM_CELLS+1];
    logic                 tail_vld;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg    <= AMP_W'(65536);
            rise_width_reg   <= 32'd65536;
            fall_width_reg   <= 32'd65536;
            flat_length_reg  <= 32'd0;
            freq_ratio_reg   <= 24'd65536;
            phase_offset_reg <= 16'd0;
            polarity_reg     <= POL_E1;
            accumulate_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_AMPLITUDE:    amplitude_reg    <= pwdata[AMP_W-1:0];
                REG_RISE_WIDTH:   rise_width_reg   <= pwdata;
                REG_FALL_WIDTH:   fall_width_reg   <= pwdata;
                REG_FLAT_LENGTH:  flat_length_reg  <= pwdata;
                REG_FREQ_RATIO:   freq_ratio_reg   <= pwdata[23:0];
                REG_PHASE_OFFSET: phase_offset_reg <= pwdata[15:0];
                REG_POLARITY:     polarity_reg     <= pwdata[2:0];
                REG_ACCUMULATE:   accumulate_reg   <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_AMPLITUDE:    prdata = 32'(amplitude_reg);
            REG_RISE_WIDTH:   prdata = rise_width_reg;
            REG_FALL_WIDTH:   prdata = fall_width_reg;
            REG_FLAT_LENGTH:  prdata = flat_length_reg;
            REG_FREQ_RATIO:   prdata = 32'(freq_ratio_reg);
            REG_PHASE_OFFSET: prdata = 32'(phase_offset_reg);
            REG_POLARITY:     prdata = 32'(polarity_reg);
            REG_ACCUMULATE:   prdata = 32'(accumulate_reg);
            default:          prdata = '0;
        endcase
    end

    // segment boundaries, registered from the width and length registers
    always_comb
    begin
        t1_next    = 34'({rise_width_reg, 1'b0}) + 34'(rise_width_reg);
        fall3_next = 34'({fall_width_reg, 1'b0}) + 34'(fall_width_reg);
        t2_next    = 35'(t1_next) + 35'(flat_length_reg);
        t3_next    = 36'(t2_next) + 36'(fall3_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg    <= 34'd196608;
            t2_reg    <= 35'd196608;
            t3_reg    <= 36'd393216;
            fall3_reg <= 34'd196608;
        end
        else
        begin
            t1_reg    <= t1_next;
            t2_reg    <= t2_next;
            t3_reg    <= t3_next;
            fall3_reg <= fall3_next;
        end
    end

    always_comb
    begin
        tm.t1           = t1_reg;
        tm.t2           = t2_reg;
        tm.t3           = t3_reg;
        tm.fall3        = fall3_reg;
        tm.rise_zero    = (rise_width_reg == '0);
        tm.fall_zero    = (fall_width_reg == '0);
        tm.freq_ratio   = freq_ratio_reg;
        tm.phase_offset = phase_offset_reg;
        oc.amplitude    = amplitude_reg;
        oc.polarity     = polarity_reg;
        oc.accumulate   = accumulate_reg;
    end

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    lpsg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .time_now (time_now),
        .tm       (tm),
        .bus_out  (cell_bus[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        lpsg_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .stage   (CELL_IDX_W'(g)),
            .bus_in  (cell_bus[g]),
            .bus_out (cell_bus[g+1])
        );
    end

    assign tail_vld = cell_bus[NUM_CELLS].vld;

    lpsg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .bus_in       (cell_bus[NUM_CELLS]),
        .oc           (oc),
        .out_valid    (out_valid),
        .e1_value     (e1_value),
        .p_value      (p_value),
        .s_value      (s_value),
        .write_mask   (write_mask),
        .add_mode     (add_mode),
        .pulse_region (pulse_region)
    );

    `LPSG_ASSERT_IMPLY(a_after_zero, clk, rst_n, out_valid && pulse_region == RGN_AFTER, e1_value == '0 && p_value == '0 && s_value == '0)
    `LPSG_ASSERT_IMPLY(a_e1_only, clk, rst_n, out_valid && write_mask == MASK_E1, p_value == '0 && s_value == '0)
    `LPSG_ASSERT_NEXT(a_stall_hold, clk, rst_n, !in_ready, $stable(tail_vld))

endmodule

// File: design/lpsg_front.sv
// front end: pulse region, slope distance, phase and quarter-turn fold
// depends on lpsg_pkg; feeds the first cell of the chain
module lpsg_front
    import lpsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [31:0] time_now,
    input  timing_t     tm,
    output cell_bus_t   bus_out
);

    logic             a_vld_reg;
    region_t          a_region_reg;
    logic [31:0]      a_dlo_reg;
    logic [MAG_W-1:0] a_mag_reg;
    logic [MAG_W-1:0] a_div_reg;
    logic             a_wzero_reg;

    region_t          a_region_next;
    logic [31:0]      a_dlo_next;
    logic [MAG_W-1:0] a_mag_next;
    logic [MAG_W-1:0] a_div_next;
    logic             a_wzero_next;
    logic [35:0]      t_ext;

    logic             b_vld_reg;
    region_t          b_region_reg;
    logic [31:0]      b_phase_reg;
    logic [MAG_W-1:0] b_mag_reg;
    logic [MAG_W-1:0] b_div_reg;
    logic             b_wzero_reg;
    logic             b_ovf_reg;
    logic [31:0]      b_phase_next;

    cell_bus_t          c_bus_reg;
    cell_bus_t          c_bus_next;
    logic signed [32:0] zs;
    logic signed [32:0] zf;
    logic               fold_neg;

    always_comb
    begin
        t_ext         = {4'b0, time_now};
        a_region_next = RGN_AFTER;
        a_dlo_next    = '0;
        a_mag_next    = '0;
        a_div_next    = tm.t1;
        a_wzero_next  = 1'b0;
        if (t_ext <= 36'(tm.t1))
        begin
            a_region_next = RGN_RISE;
            a_dlo_next    = time_now - tm.t1[31:0];
            a_mag_next    = tm.t1 - t_ext[33:0];
            a_wzero_next  = tm.rise_zero;
        end
        else if (t_ext < 36'(tm.t2))
        begin
            a_region_next = RGN_FLAT;
            a_dlo_next    = time_now - tm.t1[31:0];
        end
        else if (t_ext < tm.t3)
        begin
            a_region_next = RGN_FALL;
            a_dlo_next    = time_now - tm.t2[31:0];
            a_mag_next    = MAG_W'(t_ext - 36'(tm.t2));
            a_div_next    = tm.fall3;
            a_wzero_next  = tm.fall_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg    <= in_valid;
            a_region_reg <= a_region_next;
            a_dlo_reg    <= a_dlo_next;
            a_mag_reg    <= a_mag_next;
            a_div_reg    <= a_div_next;
            a_wzero_reg  <= a_wzero_next;
        end
    end

    // phase in turns: low word of distance times frequency, plus offset
    assign b_phase_next = 32'(56'(a_dlo_reg) * 56'(tm.freq_ratio))
                          + {tm.phase_offset, 16'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_vld_reg    <= a_vld_reg;
            b_region_reg <= a_region_reg;
            b_phase_reg  <= b_phase_next;
            b_mag_reg    <= a_mag_reg;
            b_div_reg    <= a_div_reg;
            b_wzero_reg  <= a_wzero_reg;
            b_ovf_reg    <= (a_mag_reg >= a_div_reg);
        end
    end

    // fold into a quarter turn either side of zero
    always_comb
    begin
        zs       = $signed({b_phase_reg[31], b_phase_reg});
        zf       = zs;
        fold_neg = 1'b0;
        if (zs > $signed(33'(Q30_ONE)))
        begin
            zf       = zs - $signed(33'(2 * Q30_ONE));
            fold_neg = 1'b1;
        end
        else if (zs < -$signed(33'(Q30_ONE)))
        begin
            zf       = zs + $signed(33'(2 * Q30_ONE));
            fold_neg = 1'b1;
        end
        c_bus_next         = '0;
        c_bus_next.vld     = b_vld_reg;
        c_bus_next.region  = b_region_reg;
        c_bus_next.neg     = fold_neg;
        c_bus_next.x       = $signed(CW'(CORDIC_GAIN));
        c_bus_next.y       = '0;
        c_bus_next.z       = CW'(zf);
        c_bus_next.rem     = b_mag_reg;
        c_bus_next.divisor = b_div_reg;
        c_bus_next.quo     = '0;
        c_bus_next.ovf     = b_ovf_reg;
        c_bus_next.wzero   = b_wzero_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_bus_reg <= '0;
        else if (adv)
            c_bus_reg <= c_bus_next;
    end

    assign bus_out = c_bus_reg;

endmodule

// File: design/lpsg_cell.sv
// one chain cell: cordic micro-rotation if stage < CORDIC_STAGES, restoring
// divide step if stage < IDX_BITS; depends on lpsg_pkg, chained in top level
module lpsg_cell
    import lpsg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic [CELL_IDX_W-1:0] stage,
    input  cell_bus_t             bus_in,
    output cell_bus_t             bus_out
);

    cell_bus_t            bus_reg;
    cell_bus_t            bus_next;
    logic signed [CW-1:0] x_sh;
    logic signed [CW-1:0] y_sh;
    logic signed [CW-1:0] atan;
    logic [MAG_W:0]       rem2;
    logic [MAG_W:0]       div_ext;

    always_comb
    begin
        bus_next = bus_in;
        x_sh     = bus_in.x >>> stage;
        y_sh     = bus_in.y >>> stage;
        atan     = $signed(CW'(ATAN_TABLE[ATAN_IDX_W'(stage)]));
        rem2     = {bus_in.rem, 1'b0};
        div_ext  = {1'b0, bus_in.divisor};
        if (int'(stage) < CORDIC_STAGES)
        begin
            if (!bus_in.z[CW-1])
            begin
                bus_next.x = bus_in.x - y_sh;
                bus_next.y = bus_in.y + x_sh;
                bus_next.z = bus_in.z - atan;
            end
            else
            begin
                bus_next.x = bus_in.x + y_sh;
                bus_next.y = bus_in.y - x_sh;
                bus_next.z = bus_in.z + atan;
            end
        end
        // one quotient bit of the envelope index
        if (int'(stage) < IDX_BITS)
        begin
            if (rem2 >= div_ext)
            begin
                bus_next.rem = MAG_W'(rem2 - div_ext);
                bus_next.quo = {bus_in.quo[IDX_BITS-2:0], 1'b1};
            end
            else
            begin
                bus_next.rem = MAG_W'(rem2);
                bus_next.quo = {bus_in.quo[IDX_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bus_reg <= '0;
        else if (adv)
            bus_reg <= bus_next;
    end

    assign bus_out = bus_reg;

endmodule

// File: design/lpsg_back.sv
// back end: clamp, envelope lookup, amplitude scaling, rounding and output register
// depends on lpsg_pkg; takes the last cell of the chain
module lpsg_back
    import lpsg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  cell_bus_t          bus_in,
    input  out_cfg_t           oc,
    output logic               out_valid,
    output logic [OUT_W-1:0]   e1_value,
    output logic [OUT_W-1:0]   p_value,
    output logic [OUT_W-1:0]   s_value,
    output logic [2:0]         write_mask,
    output logic               add_mode,
    output logic [1:0]         pulse_region
);

    // stage e
    logic                     e_vld_reg;
    region_t                  e_region_reg;
    logic signed [TRIG_W-1:0] e_sin_reg;
    logic signed [TRIG_W-1:0] e_cos_reg;
    logic [ENV_W-1:0]         e_env_reg;
    logic signed [CW-1:0]     x_cl;
    logic signed [CW-1:0]     y_cl;
    logic signed [TRIG_W-1:0] e_sin_next;
    logic signed [TRIG_W-1:0] e_cos_next;
    logic [IDX_BITS-1:0]      idx;
    logic [ENV_W-1:0]         e_env_next;

    // stage f
    logic                     f_vld_reg;
    region_t                  f_region_reg;
    logic signed [TRIG_W-1:0] f_sin_reg;
    logic signed [TRIG_W-1:0] f_cos_reg;
    logic [A_W-1:0]           f_a_reg;
    logic [53:0]              ae;

    // stage g
    logic                     g_vld_reg;
    region_t                  g_region_reg;
    logic signed [PROD_W-1:0] g_ps_reg;
    logic signed [PROD_W-1:0] g_pc_reg;
    logic signed [A_W:0]      a_s;

    // output register
    logic                     out_valid_reg;
    logic [OUT_W-1:0]         e1_reg;
    logic [OUT_W-1:0]         p_reg;
    logic [OUT_W-1:0]         s_reg;
    logic [2:0]               mask_reg;
    logic                     add_reg;
    region_t                  region_reg;
    logic [OUT_W-1:0]         val;
    logic [OUT_W-1:0]         cval;
    logic [OUT_W-1:0]         e1_next;
    logic [OUT_W-1:0]         p_next;
    logic [OUT_W-1:0]         s_next;
    logic [2:0]               mask_next;

    function automatic logic [OUT_W-1:0] round_sat(logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0] rs;
        longint                   v;
        rs = (prod + $signed(PROD_W'(64'd1 << 29))) >>> 30;
        v  = 64'(rs);
        if (v > SMAX)
            v = SMAX;
        if (v < SMIN)
            v = SMIN;
        return v[OUT_W-1:0];
    endfunction

    always_comb
    begin
        x_cl = bus_in.x;
        y_cl = bus_in.y;
        if (bus_in.x > $signed(CW'(Q30_ONE)))
            x_cl = $signed(CW'(Q30_ONE));
        else if (bus_in.x < -$signed(CW'(Q30_ONE)))
            x_cl = -$signed(CW'(Q30_ONE));
        if (bus_in.y > $signed(CW'(Q30_ONE)))
            y_cl = $signed(CW'(Q30_ONE));
        else if (bus_in.y < -$signed(CW'(Q30_ONE)))
            y_cl = -$signed(CW'(Q30_ONE));
        e_sin_next = bus_in.neg ? -TRIG_W'(y_cl) : TRIG_W'(y_cl);
        e_cos_next = bus_in.neg ? -TRIG_W'(x_cl) : TRIG_W'(x_cl);
        // left circular drives the s pair with the negated cosine
        if (oc.polarity == POL_LEFT)
            e_cos_next = -e_cos_next;
        if (bus_in.wzero)
            idx = '0;
        else if (bus_in.ovf)
            idx = '1;
        else
            idx = bus_in.quo;
        if (bus_in.region == RGN_FLAT)
            e_env_next = ENV_W'(Q30_ONE);
        else
            e_env_next = ENV_TABLE[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_vld_reg    <= bus_in.vld;
            e_region_reg <= bus_in.region;
            e_sin_reg    <= e_sin_next;
            e_cos_reg    <= e_cos_next;
            e_env_reg    <= e_env_next;
        end
    end

    assign ae = 54'(e_env_reg) * 54'(oc.amplitude);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_vld_reg    <= e_vld_reg;
            f_region_reg <= e_region_reg;
            f_sin_reg    <= e_sin_reg;
            f_cos_reg    <= e_cos_reg;
            f_a_reg      <= A_W'((ae + (54'd1 << 29)) >> 30);
        end
    end

    assign a_s = $signed({1'b0, f_a_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            g_vld_reg    <= f_vld_reg;
            g_region_reg <= f_region_reg;
            g_ps_reg     <= PROD_W'(a_s) * PROD_W'(f_sin_reg);
            g_pc_reg     <= PROD_W'(a_s) * PROD_W'(f_cos_reg);
        end
    end

    always_comb
    begin
        val       = (g_region_reg == RGN_AFTER) ? '0 : round_sat(g_ps_reg);
        cval      = (g_region_reg == RGN_AFTER) ? '0 : round_sat(g_pc_reg);
        e1_next   = '0;
        p_next    = '0;
        s_next    = '0;
        mask_next = MASK_NONE;
        case (oc.polarity)
            POL_E1:
            begin
                mask_next = MASK_E1;
                e1_next   = val;
            end
            POL_P:
            begin
                mask_next = MASK_P;
                p_next    = val;
            end
            POL_S:
            begin
                mask_next = MASK_S;
                s_next    = val;
            end
            POL_RIGHT, POL_LEFT:
            begin
                mask_next = MASK_PS;
                p_next    = val;
                s_next    = cval;
            end
            default:
            begin
                mask_next = MASK_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= g_vld_reg;
            if (g_vld_reg)
            begin
                e1_reg     <= e1_next;
                p_reg      <= p_next;
                s_reg      <= s_next;
                mask_reg   <= mask_next;
                add_reg    <= oc.accumulate;
                region_reg <= g_region_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign e1_value     = e1_reg;
    assign p_value      = p_reg;
    assign s_value      = s_reg;
    assign write_mask   = mask_reg;
    assign add_mode     = add_reg;
    assign pulse_region = region_reg;

endmodule
